[hdl/mcdp_pkg.sv]
// Shared types and constants for the matrix chain order solver.
// No dependencies; every other file in hdl/ but mcdp_ram.sv refers to it by scoped names.
package mcdp_pkg;

    // Fixed field widths of the word formats and the default chain capacity
    localparam int DIM_BITS         = 10;
    localparam int COST_OUT_W       = 34;
    localparam int SPLIT_W          = 5;
    localparam int MAX_MATRICES_DEF = 16;

    // Input word: one chain dimension
    typedef struct packed {
        logic [DIM_BITS-1:0] dim;
        logic                last;
    } mcdp_in_t;

    // Result word
    typedef struct packed {
        logic [COST_OUT_W-1:0] min_cost;
        logic [SPLIT_W-1:0]    first_split;
        logic                  error;
    } mcdp_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic dim_we;      // store the accepted dimension
        logic cost_we;     // write the finished interval cost
        logic cand_valid;  // a split candidate is issued this cycle
        logic cand_first;  // candidate is the lowest split of its interval
        logic diag_a;      // left sub-chain is a single matrix (cost 0)
        logic diag_b;      // right sub-chain is a single matrix (cost 0)
        logic cap_a;       // capture p[i-1] from the dimension store
        logic cap_pij;     // form p[i-1]*p[j] from the dimension store
        logic emit;        // load the result register
        logic emit_best;   // result comes from the running best
        logic emit_err;    // result flags a malformed chain
    } mcdp_cmd_t;

endpackage

[hdl/mcdp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/mcdp_ctrl.sv]
// Controller: dimension loading and the interval / split sequencer.
// Depends on mcdp_pkg for the command struct.
module mcdp_ctrl #(
    parameter int MAX_MATRICES = mcdp_pkg::MAX_MATRICES_DEF,
    localparam int ND     = MAX_MATRICES + 1,
    localparam int IDX_W  = $clog2(ND),
    localparam int CNT_W  = $clog2(ND + 1),
    localparam int ADDR_W = $clog2(ND * ND)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                last,
    output logic                busy,
    output mcdp_pkg::mcdp_cmd_t cmd,
    output logic [IDX_W-1:0]    dim_waddr,
    output logic [IDX_W-1:0]    dim_raddr,
    output logic [ADDR_W-1:0]   cost_raddr_a,
    output logic [ADDR_W-1:0]   cost_raddr_b,
    output logic [ADDR_W-1:0]   cost_waddr,
    output logic [IDX_W-1:0]    k
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PA    = 3'd1;
    localparam logic [2:0] S_PB    = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_D1    = 3'd4;
    localparam logic [2:0] S_D2    = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic             stored;
    logic [CNT_W-1:0] cnt_new;
    logic [IDX_W:0]   j_wide;
    logic [IDX_W-1:0] j;
    logic [IDX_W:0]   kp1_wide;
    logic [IDX_W-1:0] kp1;

    // Interval end and next split index
    assign j_wide   = {1'b0, i_reg} + {1'b0, r_reg} - {{IDX_W{1'b0}}, 1'b1};
    assign j        = j_wide[IDX_W-1:0];
    assign kp1_wide = {1'b0, k_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign kp1      = kp1_wide[IDX_W-1:0];

    // Dimension store fill
    assign stored  = count_reg < CNT_W'(ND);
    assign cnt_new = count_reg + CNT_W'(stored);

    assign busy      = state_reg != S_IDLE;
    assign k         = k_reg;
    assign dim_waddr = count_reg[IDX_W-1:0];

    // Cost table addresses: row * ND + column
    assign cost_raddr_a = ADDR_W'(i_reg) * ADDR_W'(ND) + ADDR_W'(k_reg);
    assign cost_raddr_b = ADDR_W'(kp1) * ADDR_W'(ND) + ADDR_W'(j);
    assign cost_waddr   = ADDR_W'(i_reg) * ADDR_W'(ND) + ADDR_W'(j);

    // Next-state and command decode
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        cmd        = '0;
        dim_raddr  = k_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.dim_we = stored;
                    count_next = cnt_new;
                    ovf_next   = ovf_reg | ~stored;
                    if (last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        n_next     = IDX_W'(cnt_new - CNT_W'(1));
                        if (ovf_reg || !stored || cnt_new < CNT_W'(2))
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_err = 1'b1;
                        end
                        else if (cnt_new == CNT_W'(2))
                        begin
                            // single matrix: zero cost, no split
                            cmd.emit = 1'b1;
                        end
                        else
                        begin
                            r_next     = IDX_W'(2);
                            i_next     = IDX_W'(1);
                            state_next = S_PA;
                        end
                    end
                end
            end

            S_PA:
            begin
                dim_raddr  = i_reg - IDX_W'(1);
                state_next = S_PB;
            end

            S_PB:
            begin
                dim_raddr  = j;
                cmd.cap_a  = 1'b1;
                k_next     = i_reg;
                state_next = S_ISSUE;
            end

            S_ISSUE:
            begin
                dim_raddr      = k_reg;
                cmd.cand_valid = 1'b1;
                cmd.cand_first = k_reg == i_reg;
                cmd.cap_pij    = k_reg == i_reg;
                cmd.diag_a     = k_reg == i_reg;
                cmd.diag_b     = kp1 == j;
                if (kp1 == j)
                begin
                    state_next = S_D1;
                end
                else
                begin
                    k_next = kp1;
                end
            end

            S_D1:
            begin
                state_next = S_D2;
            end

            S_D2:
            begin
                state_next = S_WR;
            end

            S_WR:
            begin
                cmd.cost_we = 1'b1;
                if (j == n_reg)
                begin
                    if (r_reg == n_reg)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_best = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg + IDX_W'(1);
                        i_next     = IDX_W'(1);
                        state_next = S_PA;
                    end
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_PA;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Loop indices
    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        i_reg <= i_next;
        k_reg <= k_next;
    end

endmodule

[hdl/mcdp_datapath.sv]
// Datapath: dimension store, cost table copies, split-cost pipeline, result word.
// Depends on mcdp_pkg and mcdp_ram.
module mcdp_datapath #(
    parameter int MAX_MATRICES = mcdp_pkg::MAX_MATRICES_DEF,
    localparam int ND     = MAX_MATRICES + 1,
    localparam int IDX_W  = $clog2(ND),
    localparam int ADDR_W = $clog2(ND * ND),
    localparam int DB     = mcdp_pkg::DIM_BITS,
    localparam int PROD_W = 3 * DB,
    localparam int COST_W = 3 * DB + $clog2(MAX_MATRICES) + 1,
    localparam int OUT_W  = mcdp_pkg::COST_OUT_W,
    localparam int EXT_W  = (COST_W > OUT_W) ? COST_W : OUT_W,
    localparam int SPL_W  = mcdp_pkg::SPLIT_W,
    localparam int SEXT_W = (IDX_W > SPL_W) ? IDX_W : SPL_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcdp_pkg::mcdp_cmd_t cmd,
    input  logic [DB-1:0]       dim,
    input  logic [IDX_W-1:0]    dim_waddr,
    input  logic [IDX_W-1:0]    dim_raddr,
    input  logic [ADDR_W-1:0]   cost_raddr_a,
    input  logic [ADDR_W-1:0]   cost_raddr_b,
    input  logic [ADDR_W-1:0]   cost_waddr,
    input  logic [IDX_W-1:0]    k,
    output mcdp_pkg::mcdp_out_t result,
    output logic                done
);

    logic [DB-1:0]     dim_rdata;
    logic [COST_W-1:0] cost_rdata_a, cost_rdata_b;

    logic [DB-1:0]     pa_reg;
    logic [2*DB-1:0]   pij_reg;

    logic              s1_valid_reg, s1_first_reg, s1_diag_a_reg, s1_diag_b_reg;
    logic [IDX_W-1:0]  s1_k_reg;

    logic              s2_valid_reg, s2_first_reg;
    logic [IDX_W-1:0]  s2_k_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [COST_W-1:0] sum_reg, sum_next;

    logic [COST_W-1:0] best_reg;
    logic [IDX_W-1:0]  bestk_reg;
    logic [COST_W-1:0] cand;

    logic [EXT_W-1:0]  best_ext;
    logic [OUT_W-1:0]  cost_sat;
    logic [SEXT_W-1:0] split_ext;

    mcdp_pkg::mcdp_out_t result_reg, result_next;
    logic                done_reg;

    // Dimension store
    mcdp_ram #(.WIDTH(DB), .DEPTH(ND)) u_dim_ram (
        .clk   (clk),
        .we    (cmd.dim_we),
        .waddr (dim_waddr),
        .wdata (dim),
        .raddr (dim_raddr),
        .rdata (dim_rdata)
    );

    // Two copies of the cost table, one per sub-chain read
    mcdp_ram #(.WIDTH(COST_W), .DEPTH(ND * ND)) u_cost_ram_a (
        .clk   (clk),
        .we    (cmd.cost_we),
        .waddr (cost_waddr),
        .wdata (best_reg),
        .raddr (cost_raddr_a),
        .rdata (cost_rdata_a)
    );

    mcdp_ram #(.WIDTH(COST_W), .DEPTH(ND * ND)) u_cost_ram_b (
        .clk   (clk),
        .we    (cmd.cost_we),
        .waddr (cost_waddr),
        .wdata (best_reg),
        .raddr (cost_raddr_b),
        .rdata (cost_rdata_b)
    );

    // Outer dimensions of the interval
    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            pa_reg <= dim_rdata;
        end
        if (cmd.cap_pij)
        begin
            pij_reg <= (2*DB)'(pa_reg) * (2*DB)'(dim_rdata);
        end
    end

    // Stage 2 operands: split product and sub-chain costs (single matrix costs 0)
    assign prod_next = PROD_W'(pij_reg) * PROD_W'(dim_rdata);
    assign sum_next  = (s1_diag_a_reg ? '0 : cost_rdata_a)
                     + (s1_diag_b_reg ? '0 : cost_rdata_b);
    assign cand      = sum_reg + COST_W'(prod_reg);

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.cand_valid;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= cmd.emit;
        end
    end

    // Pipeline payload and running minimum (ties keep the lower split)
    always_ff @(posedge clk)
    begin
        s1_first_reg  <= cmd.cand_first;
        s1_diag_a_reg <= cmd.diag_a;
        s1_diag_b_reg <= cmd.diag_b;
        s1_k_reg      <= k;
        s2_first_reg  <= s1_first_reg;
        s2_k_reg      <= s1_k_reg;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        if (s2_valid_reg && (s2_first_reg || cand < best_reg))
        begin
            best_reg  <= cand;
            bestk_reg <= s2_k_reg;
        end
    end

    // Result word with saturated cost
    assign best_ext  = EXT_W'(best_reg);
    assign cost_sat  = (best_ext > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                          : best_ext[OUT_W-1:0];
    assign split_ext = SEXT_W'(bestk_reg);

    always_comb
    begin
        result_next             = '0;
        result_next.error       = cmd.emit_err;
        if (cmd.emit_best)
        begin
            result_next.min_cost    = cost_sat;
            result_next.first_split = split_ext[SPL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

[hdl/matrix_chain_order_dp.sv]
// Matrix chain order solver: dimensions load one word per cycle (busy low while loading).
// An error or single-matrix result is registered in the cycle after the last word; otherwise each
// interval of length r is solved in turn by two dimension reads, r-1 split candidates through
// a 3-stage multiply/add/compare pipeline, two drain states and one table write,
// and the result strobes in the cycle after the final write. The result cannot be stalled.
// Reset (asynchronous, active low) empties the chain; the tables need no clearing.
module matrix_chain_order_dp #(
    parameter int MAX_MATRICES = mcdp_pkg::MAX_MATRICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mcdp_pkg::mcdp_in_t  item,
    output logic                done,
    output mcdp_pkg::mcdp_out_t result
);

    localparam int ND     = MAX_MATRICES + 1;
    localparam int IDX_W  = $clog2(ND);
    localparam int ADDR_W = $clog2(ND * ND);

    mcdp_pkg::mcdp_cmd_t cmd;
    logic [IDX_W-1:0]    dim_waddr, dim_raddr, k;
    logic [ADDR_W-1:0]   cost_raddr_a, cost_raddr_b, cost_waddr;

    // Sequencer
    mcdp_ctrl #(.MAX_MATRICES(MAX_MATRICES)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last         (item.last),
        .busy         (busy),
        .cmd          (cmd),
        .dim_waddr    (dim_waddr),
        .dim_raddr    (dim_raddr),
        .cost_raddr_a (cost_raddr_a),
        .cost_raddr_b (cost_raddr_b),
        .cost_waddr   (cost_waddr),
        .k            (k)
    );

    // Storage and arithmetic
    mcdp_datapath #(.MAX_MATRICES(MAX_MATRICES)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dim          (item.dim),
        .dim_waddr    (dim_waddr),
        .dim_raddr    (dim_raddr),
        .cost_raddr_a (cost_raddr_a),
        .cost_raddr_b (cost_raddr_b),
        .cost_waddr   (cost_waddr),
        .k            (k),
        .result       (result),
        .done         (done)
    );

endmodule

[sim/matrix_chain_order_dp_test.sv]
// Self-checking testbench for the matrix chain order solver: streams dimension chains,
// predicts each chain's minimum cost and top split, and checks every result word.
// Depends on hdl/mcdp_pkg.sv and hdl/matrix_chain_order_dp.sv.
module matrix_chain_order_dp_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAIN_DIMS     = mcdp_pkg::MAX_MATRICES_DEF + 1;
    localparam int RANDOM_WORDS   = 1200;
    localparam int WATCHDOG_LIMIT = 16000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int REPORT_LIMIT   = 10;

    typedef logic [mcdp_pkg::DIM_BITS-1:0] dim_t;
    localparam dim_t DIM_MAX = '1;

    typedef longint unsigned cost_t;
    localparam cost_t COST_LIMIT = (cost_t'(1) << mcdp_pkg::COST_OUT_W) - 1;

    // One pending input word; hold_for_drain keeps it back until every result is in
    typedef struct {
        mcdp_pkg::mcdp_in_t word;
        bit                 hold_for_drain;
    } pending_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    mcdp_pkg::mcdp_in_t  item = '0;
    logic                busy;
    logic                done;
    mcdp_pkg::mcdp_out_t result;

    pending_word_t       pending_words[$];
    mcdp_pkg::mcdp_out_t expected_results[$];

    // Predictor copy of the chain being loaded
    dim_t        chain_dims [CHAIN_DIMS];
    int unsigned chain_len = 0;
    bit          chain_overflow = 1'b0;

    int unsigned results_owed = 0;
    int unsigned gap_left = 0;
    int unsigned calm_words = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    bit          timed_out = 1'b0;

    matrix_chain_order_dp uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Take one accepted word into the chain; on the last word flag a malformed chain or solve it by
    // interval DP (cheapest split, lowest index on ties), and queue the result word
    function automatic void absorb_dimension(input mcdp_pkg::mcdp_in_t w);
        cost_t               cost [CHAIN_DIMS][CHAIN_DIMS];
        int unsigned         split [CHAIN_DIMS][CHAIN_DIMS];
        cost_t               best;
        cost_t               trial;
        int unsigned         n;
        int unsigned         j;
        int unsigned         best_k;
        mcdp_pkg::mcdp_out_t r;
        if (chain_len < CHAIN_DIMS)
        begin
            chain_dims[chain_len] = w.dim;
            chain_len++;
        end
        else
            chain_overflow = 1'b1;
        if (!w.last)
            return;
        r = '0;
        if (chain_overflow || chain_len < 2)
            r.error = 1'b1;
        else
        begin
            n = chain_len - 1;
            for (int i = 1; i <= n; i++)
            begin
                cost[i][i] = cost_t'(0);
                split[i][i] = 0;
            end
            for (int span = 2; span <= n; span++)
            begin
                for (int i = 1; i + span - 1 <= n; i++)
                begin
                    j = i + span - 1;
                    best = cost_t'(0);
                    best_k = i;
                    for (int k = i; k < j; k++)
                    begin
                        trial = (k == i ? cost_t'(0) : cost[i][k]) + cost[k + 1][j]
                              + cost_t'(chain_dims[i - 1]) * cost_t'(chain_dims[k])
                              * cost_t'(chain_dims[j]);
                        if (k == i || trial < best)
                        begin
                            best = trial;
                            best_k = k;
                        end
                    end
                    cost[i][j] = best;
                    split[i][j] = best_k;
                end
            end
            r.min_cost = (cost[1][n] > COST_LIMIT)
                       ? COST_LIMIT[mcdp_pkg::COST_OUT_W-1:0]
                       : cost[1][n][mcdp_pkg::COST_OUT_W-1:0];
            r.first_split = (n >= 2) ? split[1][n][mcdp_pkg::SPLIT_W-1:0] : '0;
        end
        expected_results.push_back(r);
        chain_len = 0;
        chain_overflow = 1'b0;
    endfunction

    // Sender idle time after a word: mostly none or short, sometimes long,
    // with occasional stretches of back-to-back words
    function automatic int unsigned next_gap();
        int unsigned pick;
        if (calm_words > 0)
        begin
            calm_words--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2)
            calm_words = $urandom_range(30, 120);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_word(input dim_t dim, input bit last,
                            input bit hold_for_drain);
        pending_word_t p;
        p.word.dim = dim;
        p.word.last = last;
        p.hold_for_drain = hold_for_drain;
        pending_words.push_back(p);
    endtask

    // Queue a whole chain; style picks how the dimensions are drawn
    task automatic add_chain(input int unsigned len, input int unsigned style,
                             input bit hold_for_drain);
        dim_t shared;
        dim_t d;
        shared = dim_t'($urandom_range(1, DIM_MAX));
        for (int unsigned i = 0; i < len; i++)
        begin
            case (style)
                1: d = shared;
                2:
                begin
                    case ($urandom_range(0, 3))
                        0: d = '0;
                        1: d = dim_t'(1);
                        2: d = DIM_MAX;
                        default: d = dim_t'($urandom_range(0, DIM_MAX));
                    endcase
                end
                3: d = dim_t'($urandom_range(1, 4));
                default: d = dim_t'($urandom_range(1, DIM_MAX));
            endcase
            add_word(d, i == len - 1, hold_for_drain && i == 0);
        end
    endtask

    // Driver: presents the front pending word, holds it until accepted
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        bit took;
        bit raise;
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
        end
        else
        begin
            took = start && !busy;
            raise = 1'b0;
            if (took)
            begin
                absorb_dimension(pending_words[0].word);
                if (pending_words[0].word.last)
                    results_owed++;
                pending_words.pop_front();
                gap_left = next_gap();
            end
            if (done && results_owed > 0)
                results_owed--;
            if (start && !took)
                raise = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (pending_words.size() != 0
                     && !(pending_words[0].hold_for_drain && results_owed != 0))
                raise = 1'b1;
            start <= raise;
            if (raise)
                item <= pending_words[0].word;
        end
    end

    task automatic report_bad_word(input string what, input mcdp_pkg::mcdp_out_t want,
                                   input mcdp_pkg::mcdp_out_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display({"%0t bad result word (%s): expected cost=%0d split=%0d err=%0b,",
                      " got cost=%0d split=%0d err=%0b"},
                     $realtime, what, want.min_cost, want.first_split, want.error,
                     got.min_cost, got.first_split, got.error);
    endtask

    // Monitor: checks each strobed result word, and the watchdog
    always @(posedge clk)
    begin : check_results
        mcdp_pkg::mcdp_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_bad_word("none expected", '0, result);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.min_cost !== want.min_cost
                        || result.first_split !== want.first_split
                        || result.error !== want.error)
                        report_bad_word("fields differ", want, result);
                end
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end
    end

    initial
    begin : stimulus
        int unsigned queued;
        int unsigned pick;
        int unsigned len;
        int unsigned style;
        bit          first_random;

        // Directed: too few dimensions
        add_word(DIM_MAX, 1'b1, 1'b0);
        // Single matrix
        add_word(dim_t'(1), 1'b0, 1'b0);
        add_word(DIM_MAX, 1'b1, 1'b0);
        // Zero dimension in the products
        add_word(dim_t'(7), 1'b0, 1'b0);
        add_word('0, 1'b0, 1'b0);
        add_word(dim_t'(9), 1'b1, 1'b0);
        // Three trailing 2s; the splits tie, resolving to the lowest index, only if the first dimension is 2
        add_chain(4, 1, 1'b0);
        for (int i = 0; i < 3; i++)
            pending_words[$ - i].word.dim = dim_t'(2);
        // Longest chain at the largest dimension
        for (int i = 0; i < CHAIN_DIMS; i++)
            add_word(DIM_MAX, i == CHAIN_DIMS - 1, 1'b0);

        // Random chains, mostly well formed and short
        queued = 0;
        first_random = 1'b1;
        while (queued < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len = 1;
            else if (pick < 10)
                len = $urandom_range(CHAIN_DIMS + 1, CHAIN_DIMS + 4);
            else if (pick < 20)
                len = $urandom_range(7, CHAIN_DIMS - 1);
            else if (pick < 25)
                len = CHAIN_DIMS;
            else
                len = $urandom_range(2, 6);
            pick = $urandom_range(0, 99);
            style = (pick < 70) ? 0 : (pick < 80) ? 1 : (pick < 90) ? 2 : 3;
            add_chain(len, style, first_random || $urandom_range(0, 9) == 0);
            first_random = 1'b0;
            queued += len;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (timed_out || (pending_words.size() == 0 && expected_results.size() == 0));
        if (!timed_out)
            repeat (SETTLE_CYCLES) @(posedge clk);
        if (!timed_out && mismatch_count == 0 && expected_results.size() == 0)
            $display("matrix_chain_order_dp: match");
        else
            $display("matrix_chain_order_dp: mismatch");
        $finish;
    end

endmodule
